/* design/scrolling_text_console_buffer_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the scrolling text console buffer
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SCROLLING_TEXT_CONSOLE_BUFFER_ASSERT_SVH
`define SCROLLING_TEXT_CONSOLE_BUFFER_ASSERT_SVH

// same-cycle implication
`define STCB_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define STCB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/stcb_pkg.sv */
// ----------------------------------------------------------------------------
// stcb_pkg
// Shared constants, command codes and the queued command word.
// ----------------------------------------------------------------------------
package stcb_pkg;

  localparam int unsigned DefRows      = 10;
  localparam int unsigned DefCols      = 15;

  localparam int unsigned CharW        = 8;
  localparam int unsigned RowFieldW    = 4;
  localparam int unsigned ColFieldW    = 4;
  localparam int unsigned CursorFieldW = 4;

  localparam int unsigned FifoDepth    = 2;

  localparam logic [CharW-1:0] ChFormFeed = 8'h0C;
  localparam logic [CharW-1:0] ChNewline  = 8'h0A;
  localparam logic [CharW-1:0] ChSpace    = 8'h20;

  typedef enum logic [2:0] {
    CMD_READ,
    CMD_CLEAR,
    CMD_NEWLINE,
    CMD_CONTROL,
    CMD_PRINT
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e              kind;
    logic [CharW-1:0]       ch;
    logic [RowFieldW-1:0]   row;
    logic [ColFieldW-1:0]   col;
    logic                   in_range;
  } cmd_t;

endpackage

/* design/stcb_if.sv */
// ----------------------------------------------------------------------------
// stcb_in_if / stcb_out_if
// Valid/ready channels for request words and read result words.
// ----------------------------------------------------------------------------
interface stcb_in_if;
  logic                             valid;
  logic                             ready;
  logic                             operation;
  logic [stcb_pkg::CharW-1:0]       char_in;
  logic [stcb_pkg::RowFieldW-1:0]   read_row;
  logic [stcb_pkg::ColFieldW-1:0]   read_column;

  modport source (output valid, output operation, output char_in, output read_row,
                  output read_column, input ready);
  modport sink   (input valid, input operation, input char_in, input read_row,
                  input read_column, output ready);
endinterface

interface stcb_out_if;
  logic                              valid;
  logic                              ready;
  logic [stcb_pkg::CharW-1:0]        cell_char;
  logic [stcb_pkg::CursorFieldW-1:0] cursor_column;

  modport source (output valid, output cell_char, output cursor_column, input ready);
  modport sink   (input valid, input cell_char, input cursor_column, output ready);
endinterface

/* design/stcb_front.sv */
// ----------------------------------------------------------------------------
// stcb_front
// Accept request words and classify them into queued commands.
// ----------------------------------------------------------------------------
module stcb_front #(
  parameter int unsigned ROWS = stcb_pkg::DefRows,
  parameter int unsigned COLS = stcb_pkg::DefCols
) (
  stcb_in_if.sink         in_i,
  input  logic            full_i,
  output logic            push_o,
  output stcb_pkg::cmd_t  cmd_o
);

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  always_comb begin
    cmd_o.ch       = in_i.char_in;
    cmd_o.row      = in_i.read_row;
    cmd_o.col      = in_i.read_column;
    cmd_o.in_range = (32'(in_i.read_row) < ROWS) && (32'(in_i.read_column) < COLS);
    priority if (in_i.operation) begin
      cmd_o.kind = stcb_pkg::CMD_READ;
    end else if (in_i.char_in == stcb_pkg::ChFormFeed) begin
      cmd_o.kind = stcb_pkg::CMD_CLEAR;
    end else if (in_i.char_in == stcb_pkg::ChNewline) begin
      cmd_o.kind = stcb_pkg::CMD_NEWLINE;
    end else if (in_i.char_in < stcb_pkg::ChSpace) begin
      cmd_o.kind = stcb_pkg::CMD_CONTROL;
    end else begin
      cmd_o.kind = stcb_pkg::CMD_PRINT;
    end
  end

endmodule

/* design/stcb_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// stcb_cmd_fifo
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
`include "scrolling_text_console_buffer_assert.svh"

module stcb_cmd_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  stcb_pkg::cmd_t  cmd_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output stcb_pkg::cmd_t  cmd_o
);

  localparam int unsigned PtrW = (stcb_pkg::FifoDepth > 1) ? $clog2(stcb_pkg::FifoDepth) : 1;
  localparam int unsigned CntW = $clog2(stcb_pkg::FifoDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(stcb_pkg::FifoDepth - 1);

  stcb_pkg::cmd_t  entries_q [stcb_pkg::FifoDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(stcb_pkg::FifoDepth));
  assign valid_o = (count_q != '0);
  assign cmd_o   = entries_q[rd_q];

  always_comb begin
    wr_d    = wr_q;
    rd_d    = rd_q;
    count_d = count_q;
    if (push_i) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_q] <= cmd_i;
    end
  end

  `STCB_ASSERT_IMPLY(a_no_overflow, push_i, count_q < CntW'(stcb_pkg::FifoDepth) || pop_i, "command queue overflow")
  `STCB_ASSERT_IMPLY(a_no_underflow, pop_i, count_q != '0, "command queue underflow")
  `STCB_ASSERT_NEXT(a_push_seen, push_i && !pop_i, count_q != '0, "pushed word not counted")

endmodule

/* design/stcb_back.sv */
// ----------------------------------------------------------------------------
// stcb_back
// Execute commands against the cell memory and drive read results.
// ----------------------------------------------------------------------------
`include "scrolling_text_console_buffer_assert.svh"

module stcb_back #(
  parameter int unsigned ROWS = stcb_pkg::DefRows,
  parameter int unsigned COLS = stcb_pkg::DefCols
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  input  stcb_pkg::cmd_t  cmd_i,
  output logic            pop_o,
  stcb_out_if.source      out_o
);

  localparam int unsigned RowW  = $clog2(ROWS);
  localparam int unsigned ColW  = $clog2(COLS);
  localparam int unsigned LenW  = $clog2(COLS + 1);
  localparam int unsigned Cells = ROWS * COLS;
  localparam int unsigned AddrW = $clog2(Cells);
  localparam int unsigned CurW  = stcb_pkg::CursorFieldW;

  logic [stcb_pkg::CharW-1:0] mem [Cells];

  logic [RowW-1:0]            top_q, top_d;
  logic [LenW-1:0]            cursor_q, cursor_d;
  logic [LenW-1:0]            len_q [ROWS];
  logic [LenW-1:0]            len_d [ROWS];
  logic                       out_valid_q, out_valid_d;
  logic [stcb_pkg::CharW-1:0] rdata_q;
  logic                       keep_q;
  logic [CurW-1:0]            snap_q;

  logic [RowW+stcb_pkg::RowFieldW-1:0] row_wide;
  logic [ColW+stcb_pkg::ColFieldW-1:0] col_wide;
  logic [LenW+CurW-1:0]                cur_wide;
  logic [RowW-1:0]                     row_idx, prow, top_inc, bottom, wr_row;
  logic [ColW-1:0]                     col_idx;
  logic [RowW:0]                       prow_sum;
  logic [LenW-1:0]                     wr_col, cursor_next;
  logic [AddrW-1:0]                    rd_addr, wr_addr;
  logic                                is_read, scroll, rd_en, wr_en, keep_d;

  assign row_wide = {{RowW{1'b0}}, cmd_i.row};
  assign col_wide = {{ColW{1'b0}}, cmd_i.col};
  assign cur_wide = {{CurW{1'b0}}, cursor_q};
  assign row_idx  = row_wide[RowW-1:0];
  assign col_idx  = col_wide[ColW-1:0];

  assign prow_sum = {1'b0, top_q} + {1'b0, row_idx};
  assign prow     = (prow_sum >= (RowW+1)'(ROWS)) ? RowW'(prow_sum - (RowW+1)'(ROWS))
                                                  : prow_sum[RowW-1:0];
  assign rd_addr  = AddrW'(prow) * AddrW'(COLS) + AddrW'(col_idx);
  assign keep_d   = cmd_i.in_range && (LenW'(col_idx) < len_q[prow]);

  assign top_inc  = (top_q == RowW'(ROWS - 1)) ? '0 : top_q + 1'b1;
  assign bottom   = (top_q == '0) ? RowW'(ROWS - 1) : top_q - 1'b1;

  assign is_read  = (cmd_i.kind == stcb_pkg::CMD_READ);
  assign scroll   = (cmd_i.kind == stcb_pkg::CMD_NEWLINE)
                 || (((cmd_i.kind == stcb_pkg::CMD_CONTROL) || (cmd_i.kind == stcb_pkg::CMD_PRINT))
                     && (cursor_q == LenW'(COLS)));
  assign wr_row      = scroll ? top_q : bottom;
  assign wr_col      = scroll ? '0 : cursor_q;
  assign cursor_next = wr_col + 1'b1;
  assign wr_addr     = AddrW'(wr_row) * AddrW'(COLS) + AddrW'(wr_col);

  assign pop_o = cmd_valid_i && (!is_read || !out_valid_q || out_o.ready);
  assign rd_en = pop_o && is_read;
  assign wr_en = pop_o && (cmd_i.kind == stcb_pkg::CMD_PRINT);

  always_comb begin
    top_d    = top_q;
    cursor_d = cursor_q;
    len_d    = len_q;
    if (pop_o) begin
      unique case (cmd_i.kind)
        stcb_pkg::CMD_CLEAR: begin
          len_d    = '{default: '0};
          cursor_d = '0;
        end
        stcb_pkg::CMD_NEWLINE, stcb_pkg::CMD_CONTROL: begin
          if (scroll) begin
            top_d        = top_inc;
            len_d[top_q] = '0;
            cursor_d     = '0;
          end
        end
        stcb_pkg::CMD_PRINT: begin
          if (scroll) begin
            top_d        = top_inc;
            len_d[top_q] = '0;
          end
          len_d[wr_row] = cursor_next;
          cursor_d      = cursor_next;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    priority if (rd_en) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q       <= '0;
      cursor_q    <= '0;
      len_q       <= '{default: '0};
      out_valid_q <= 1'b0;
    end else begin
      top_q       <= top_d;
      cursor_q    <= cursor_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= cmd_i.ch;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
      keep_q  <= keep_d;
      snap_q  <= cur_wide[CurW-1:0];
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.cell_char     = keep_q ? rdata_q : '0;
  assign out_o.cursor_column = snap_q;

  `STCB_ASSERT_IMPLY(a_cursor_bound, 1'b1, cursor_q <= LenW'(COLS), "cursor beyond row end")
  `STCB_ASSERT_IMPLY(a_top_bound, 1'b1, top_q <= RowW'(ROWS - 1), "top row pointer out of range")
  `STCB_ASSERT_NEXT(a_clear_home, pop_o && (cmd_i.kind == stcb_pkg::CMD_CLEAR), cursor_q == '0, "form feed left cursor off home")
  `STCB_ASSERT_NEXT(a_scroll_moves, pop_o && scroll, top_q != $past(top_q), "scroll did not advance top row")
  `STCB_ASSERT_NEXT(a_read_result, rd_en, out_valid_q, "read issued without result")

endmodule

/* design/scrolling_text_console_buffer.sv */
// ----------------------------------------------------------------------------
// scrolling_text_console_buffer
// ROWS x COLS text console store with scrolling bottom-row cursor.
// ----------------------------------------------------------------------------
// One request word is taken per cycle while the two-entry command queue has
// room. The back end gives the cell memory one character write or one cell
// read per cycle, and holds a read in the queue while an untaken result sits
// on the output. A read result passes through the command queue and the
// output register and is held on the output until taken. Form feed and
// scroll update per-row fill lengths and a top-row pointer, never the cells,
// so reset needs no clearing pass over the memory.
module scrolling_text_console_buffer #(
  parameter int unsigned ROWS = stcb_pkg::DefRows,
  parameter int unsigned COLS = stcb_pkg::DefCols
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  stcb_in_if.sink      in_i,
  stcb_out_if.source   out_o
);

  stcb_pkg::cmd_t push_cmd, head_cmd;
  logic           push, full, pop, head_valid;

  stcb_front #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_front (
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .cmd_o  (push_cmd)
  );

  stcb_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .cmd_o   (head_cmd)
  );

  stcb_back #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (head_valid),
    .cmd_i       (head_cmd),
    .pop_o       (pop),
    .out_o       (out_o)
  );

endmodule
